[sv/utf8_decode_with_display_width_assert.svh]
// Assertion macros shared by the checker of the UTF-8 decoder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef UTF8_DECODE_WITH_DISPLAY_WIDTH_ASSERT_SVH
`define UTF8_DECODE_WITH_DISPLAY_WIDTH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define U8DW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder assertion failed");

// Next-cycle implication, checked outside reset.
`define U8DW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder assertion failed");

`endif

[sv/utf8dw_pkg.sv]
// Shared types and constants for the UTF-8 decoder with display width.
// Used by every module of the block; depends on nothing.
package utf8dw_pkg;

    localparam int CP_W    = 21;
    localparam int COUNT_W = 3;
    localparam int COLS_W  = 2;

    localparam logic [CP_W-1:0]    REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [COLS_W-1:0]  COLS_NARROW    = 2'd1;
    localparam logic [COLS_W-1:0]  COLS_WIDE      = 2'd2;

    localparam logic [COUNT_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [COUNT_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [COUNT_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [COUNT_W-1:0] LEN_THREE = 3'd3;
    localparam logic [COUNT_W-1:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]    scalar_value;
        logic [COUNT_W-1:0] byte_count;
        logic               malformed;
        logic [COLS_W-1:0]  display_width;
    } result_t;

endpackage

[sv/utf8dw_width.sv]
// Terminal column classifier: wide for the CJK ideograph blocks, narrow otherwise.
// Depends on utf8dw_pkg.
module utf8dw_width
(
    input  logic [utf8dw_pkg::CP_W-1:0]   scalar_value,
    output logic [utf8dw_pkg::COLS_W-1:0] display_width
);

    logic wide;

    always_comb
    begin
        wide = ((scalar_value >= 21'h004E00) && (scalar_value <= 21'h009FFF))
            || ((scalar_value >= 21'h003400) && (scalar_value <= 21'h004DBF))
            || ((scalar_value >= 21'h020000) && (scalar_value <= 21'h02A6DF))
            || ((scalar_value >= 21'h02A700) && (scalar_value <= 21'h02EBEF))
            || ((scalar_value >= 21'h030000) && (scalar_value <= 21'h03134F))
            || ((scalar_value >= 21'h00F900) && (scalar_value <= 21'h00FAFF))
            || ((scalar_value >= 21'h02F800) && (scalar_value <= 21'h02FA1F));
        display_width = wide ? utf8dw_pkg::COLS_WIDE : utf8dw_pkg::COLS_NARROW;
    end

endmodule

[sv/utf8dw_decode.sv]
// Sequence decoder: holds the pending multi-byte sequence and forms one result.
// Depends on utf8dw_pkg and utf8dw_width.
module utf8dw_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          text_byte,
    output logic                has_result,
    output utf8dw_pkg::result_t result
);

    logic [utf8dw_pkg::COUNT_W-1:0] expected_reg, expected_next;
    logic [utf8dw_pkg::COUNT_W-1:0] seen_reg, seen_next;
    logic [utf8dw_pkg::CP_W-1:0]    partial_reg, partial_next;

    logic [utf8dw_pkg::COUNT_W-1:0] count;
    logic [utf8dw_pkg::CP_W-1:0]    shifted;
    logic                           is_cont;
    logic [utf8dw_pkg::CP_W-1:0]    res_cp;
    logic [utf8dw_pkg::COUNT_W-1:0] res_count;
    logic                           res_bad;
    logic [utf8dw_pkg::COLS_W-1:0]  res_cols;

    utf8dw_width u_width
    (
        .scalar_value  (res_cp),
        .display_width (res_cols)
    );

    always_comb
    begin
        is_cont       = (text_byte[7:6] == 2'b10);
        count         = seen_reg + 3'd1;
        shifted       = {partial_reg[utf8dw_pkg::CP_W-7:0], text_byte[5:0]};
        expected_next = expected_reg;
        seen_next     = seen_reg;
        partial_next  = partial_reg;
        has_result    = 1'b0;
        res_cp        = utf8dw_pkg::REPLACEMENT_CP;
        res_count     = utf8dw_pkg::LEN_ONE;
        res_bad       = 1'b0;

        if (expected_reg != utf8dw_pkg::LEN_NONE)
        begin
            if (!is_cont)
            begin
                // consume the bad byte as part of the broken sequence
                has_result    = 1'b1;
                res_count     = count;
                res_bad       = 1'b1;
                expected_next = utf8dw_pkg::LEN_NONE;
                seen_next     = '0;
                partial_next  = '0;
            end
            else if (count >= expected_reg)
            begin
                has_result    = 1'b1;
                res_cp        = shifted;
                res_count     = expected_reg;
                expected_next = utf8dw_pkg::LEN_NONE;
                seen_next     = '0;
                partial_next  = '0;
            end
            else
            begin
                seen_next    = count;
                partial_next = shifted;
            end
        end
        else if (!text_byte[7])
        begin
            has_result = 1'b1;
            res_cp     = {13'd0, text_byte};
        end
        else if (is_cont || (text_byte[7:3] == 5'b11111))
        begin
            has_result = 1'b1;
            res_bad    = 1'b1;
        end
        else
        begin
            seen_next = utf8dw_pkg::LEN_ONE;
            if (text_byte[7:5] == 3'b110)
            begin
                expected_next = utf8dw_pkg::LEN_TWO;
                partial_next  = {16'd0, text_byte[4:0]};
            end
            else if (text_byte[7:4] == 4'b1110)
            begin
                expected_next = utf8dw_pkg::LEN_THREE;
                partial_next  = {17'd0, text_byte[3:0]};
            end
            else
            begin
                expected_next = utf8dw_pkg::LEN_FOUR;
                partial_next  = {18'd0, text_byte[2:0]};
            end
        end

        result.scalar_value  = res_cp;
        result.byte_count    = res_count;
        result.malformed     = res_bad;
        result.display_width = res_cols;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= utf8dw_pkg::LEN_NONE;
            seen_reg     <= '0;
            partial_reg  <= '0;
        end
        else if (step)
        begin
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
            partial_reg  <= partial_next;
        end
    end

endmodule

[sv/utf8_decode_with_display_width.sv]
// UTF-8 decoder with terminal display width. Takes one byte per cycle on the
// s_ side while m_ does not stall and returns one code point per completed or
// broken sequence on the m_ side. Throughput is one byte every cycle under the
// same condition; an accepted byte goes to the input register, then the result
// register, and the single pass through the sequence-state register sets the
// rate. Bytes that only extend a pending sequence give no result. A malformed
// sequence returns U+FFFD with the malformed flag in m_tuser.
module utf8_decode_with_display_width
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [20:0] scalar_value, [23:21] byte_count,
                                  // [25:24] display_width, [31:26] zero
    output logic [0:0]  m_tuser   // [0] malformed
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                out_valid_reg;
    utf8dw_pkg::result_t out_reg;
    logic                advance;
    logic                step;
    logic                has_result;
    utf8dw_pkg::result_t result;

    // the input stage moves whenever the result register is free to load
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    utf8dw_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .text_byte  (in_byte_reg),
        .has_result (has_result),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= step && has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (step && has_result)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.display_width, out_reg.byte_count, out_reg.scalar_value};
    assign m_tuser  = out_reg.malformed;

endmodule

[sv/utf8dw_checker.sv]
// Port-level checker for the UTF-8 decoder, bound to the top level.
// Depends on utf8dw_pkg and the assertion macro header.
`include "utf8_decode_with_display_width_assert.svh"

module utf8dw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic [2:0] bc;
    logic [1:0] cols;

    assign bc   = m_tdata[23:21];
    assign cols = m_tdata[25:24];

    // hold a stalled result
    `U8DW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    `U8DW_ASSERT_NOW(a_bad_is_fffd, m_tvalid && m_tuser[0],
        (m_tdata[20:0] == utf8dw_pkg::REPLACEMENT_CP) && (cols == utf8dw_pkg::COLS_NARROW))

    `U8DW_ASSERT_NOW(a_count_range, m_tvalid,
        (bc == 3'd1 || bc == 3'd2 || bc == 3'd3 || bc == 3'd4) && (m_tdata[31:26] == 6'd0))

    // a good single byte result is plain ASCII
    `U8DW_ASSERT_NOW(a_single_ascii, m_tvalid && !m_tuser[0] && (bc == 3'd1),
        (m_tdata[20:7] == 14'd0) && (cols == utf8dw_pkg::COLS_NARROW))

    // the input side never stalls while the pipeline is empty downstream
    `U8DW_ASSERT_NOW(a_ready_when_drained, !m_tvalid && s_tvalid && $past(!s_tvalid),
        s_tready)

endmodule

bind utf8_decode_with_display_width utf8dw_checker u_utf8dw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/testbench.sv]
// Self-checking bench for the UTF-8 decoder with display width: random and directed
// byte requests go in, and each decoded code point is compared with a local predictor.
// Depends on utf8dw_pkg and the utf8_decode_with_display_width top module.
module testbench;

    localparam int BYTE_TARGET = 800;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 16;

    class decode_scoreboard;
        utf8dw_pkg::result_t            pending_q[$];
        logic [utf8dw_pkg::COUNT_W-1:0] seq_len;
        logic [utf8dw_pkg::COUNT_W-1:0] seq_taken;
        logic [utf8dw_pkg::CP_W-1:0]    seq_value;
        int                             errors;

        function new();
            seq_len   = utf8dw_pkg::LEN_NONE;
            seq_taken = utf8dw_pkg::LEN_NONE;
            seq_value = '0;
            errors    = 0;
        endfunction

        task report(input string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            errors++;
        endtask

        function logic [utf8dw_pkg::COLS_W-1:0] columns_for(
            input logic [utf8dw_pkg::CP_W-1:0] cp);
            if ((cp >= 21'h04E00 && cp <= 21'h09FFF) || (cp >= 21'h03400 && cp <= 21'h04DBF) ||
                (cp >= 21'h20000 && cp <= 21'h2A6DF) || (cp >= 21'h2A700 && cp <= 21'h2EBEF) ||
                (cp >= 21'h30000 && cp <= 21'h3134F) || (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
                (cp >= 21'h2F800 && cp <= 21'h2FA1F))
                return utf8dw_pkg::COLS_WIDE;
            return utf8dw_pkg::COLS_NARROW;
        endfunction

        // Advance the sequence state by one accepted byte; queue a result if one is due.
        function void note_byte(input logic [7:0] b);
            utf8dw_pkg::result_t r;
            logic                due;
            due = 1'b0;
            r   = '0;
            if (seq_len != utf8dw_pkg::LEN_NONE)
            begin
                if (b[7:6] != 2'b10)
                begin
                    r.scalar_value = utf8dw_pkg::REPLACEMENT_CP;
                    r.byte_count   = seq_taken + 3'd1;
                    r.malformed    = 1'b1;
                    due            = 1'b1;
                end
                else
                begin
                    seq_value = {seq_value[utf8dw_pkg::CP_W-7:0], b[5:0]};
                    seq_taken = seq_taken + 3'd1;
                    if (seq_taken >= seq_len)
                    begin
                        r.scalar_value = seq_value;
                        r.byte_count   = seq_len;
                        r.malformed    = 1'b0;
                        due            = 1'b1;
                    end
                end
                if (due)
                begin
                    seq_len   = utf8dw_pkg::LEN_NONE;
                    seq_taken = utf8dw_pkg::LEN_NONE;
                    seq_value = '0;
                end
            end
            else if (b < 8'h80)
            begin
                r.scalar_value = {13'd0, b};
                r.byte_count   = utf8dw_pkg::LEN_ONE;
                r.malformed    = 1'b0;
                due            = 1'b1;
            end
            else if (b < 8'hC0 || b >= 8'hF8)
            begin
                r.scalar_value = utf8dw_pkg::REPLACEMENT_CP;
                r.byte_count   = utf8dw_pkg::LEN_ONE;
                r.malformed    = 1'b1;
                due            = 1'b1;
            end
            else
            begin
                seq_taken = utf8dw_pkg::LEN_ONE;
                if (b < 8'hE0)
                begin
                    seq_len   = utf8dw_pkg::LEN_TWO;
                    seq_value = {16'd0, b[4:0]};
                end
                else if (b < 8'hF0)
                begin
                    seq_len   = utf8dw_pkg::LEN_THREE;
                    seq_value = {17'd0, b[3:0]};
                end
                else
                begin
                    seq_len   = utf8dw_pkg::LEN_FOUR;
                    seq_value = {18'd0, b[2:0]};
                end
            end
            if (due)
            begin
                r.display_width = columns_for(r.scalar_value);
                pending_q.push_back(r);
            end
        endfunction

        task check_result(input utf8dw_pkg::result_t got);
            utf8dw_pkg::result_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result cp=%h count=%0d", got.scalar_value,
                                 got.byte_count));
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.scalar_value !== want.scalar_value)
                    report($sformatf("scalar_value %h, want %h", got.scalar_value,
                                     want.scalar_value));
                if (got.byte_count !== want.byte_count)
                    report($sformatf("byte_count %0d, want %0d (cp %h)", got.byte_count,
                                     want.byte_count, want.scalar_value));
                if (got.malformed !== want.malformed)
                    report($sformatf("malformed %b, want %b (cp %h)", got.malformed,
                                     want.malformed, want.scalar_value));
                if (got.display_width !== want.display_width)
                    report($sformatf("display_width %0d, want %0d (cp %h)", got.display_width,
                                     want.display_width, want.scalar_value));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    decode_scoreboard sb;
    int               burst_left = 0;
    int               bytes_sent = 0;

    logic [utf8dw_pkg::CP_W-1:0] range_edges[28] = '{
        21'h033FF, 21'h03400, 21'h04DBF, 21'h04DC0, 21'h04DFF, 21'h04E00, 21'h09FFF,
        21'h0A000, 21'h0F8FF, 21'h0F900, 21'h0FAFF, 21'h0FB00, 21'h1FFFF, 21'h20000,
        21'h2A6DF, 21'h2A6E0, 21'h2A6FF, 21'h2A700, 21'h2EBEF, 21'h2EBF0, 21'h2F7FF,
        21'h2F800, 21'h2FA1F, 21'h2FA20, 21'h2FFFF, 21'h30000, 21'h3134F, 21'h31350
    };

    utf8_decode_with_display_width dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drive one byte request; open a new burst after a random gap when the old one runs out.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge clk); while (!s_tready);
        sb.note_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_encoded(input logic [utf8dw_pkg::CP_W-1:0] cp, input int len);
        int i;
        case (len)
            1:       send_byte({1'b0, cp[6:0]});
            2:       send_byte({3'b110, cp[10:6]});
            3:       send_byte({4'b1110, cp[15:12]});
            default: send_byte({5'b11110, cp[20:18]});
        endcase
        for (i = 1; i < len; i++)
            send_byte({2'b10, cp[6*(len-1-i) +: 6]});
    endtask

    // Mostly well-formed characters, plus raw noise and sequences cut by a bad byte.
    task automatic send_random_char();
        int                          pick;
        int                          len;
        int                          i;
        logic [utf8dw_pkg::CP_W-1:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 22)
        begin
            len = $urandom_range(2, 4);
            case (len)
                2:       send_byte(8'($urandom_range(8'hC0, 8'hDF)));
                3:       send_byte(8'($urandom_range(8'hE0, 8'hEF)));
                default: send_byte(8'($urandom_range(8'hF0, 8'hF7)));
            endcase
            for (i = $urandom_range(0, len - 2); i > 0; i--)
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
            if ($urandom_range(0, 1) == 0)
                send_byte(8'($urandom_range(8'h00, 8'h7F)));
            else
                send_byte(8'($urandom_range(8'hC0, 8'hFF)));
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:       cp = utf8dw_pkg::CP_W'($urandom_range(0, 21'h7F));
                1:       cp = utf8dw_pkg::CP_W'($urandom_range(21'h80, 21'h7FF));
                2:       cp = utf8dw_pkg::CP_W'($urandom_range(21'h800, 21'hFFFF));
                3:       cp = utf8dw_pkg::CP_W'($urandom_range(21'h10000, 21'h1FFFFF));
                4:       cp = utf8dw_pkg::CP_W'($urandom_range(
                                  range_edges[2 * $urandom_range(0, 6) + 1], 21'h3134F));
                default: cp = range_edges[$urandom_range(0, 27)];
            endcase
            len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            // Overlong forms are decoded as is.
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(len, 4);
            send_encoded(cp, len);
        end
    endtask

    // Receiver stall pattern: phases of always ready, light, heavy and very heavy stalls.
    initial
    begin : sink_pattern
        int mode;
        int span;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = ($urandom_range(0, 3) != 0);
                    2:       m_tready = ($urandom_range(0, 1) == 0);
                    default: m_tready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        utf8dw_pkg::result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.scalar_value  = m_tdata[20:0];
            got.byte_count    = m_tdata[23:21];
            got.display_width = m_tdata[25:24];
            got.malformed     = m_tuser[0];
            sb.check_result(got);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : main
        logic [7:0] directed[$];
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Field extremes, stray continuations, invalid leads, every length, wide ranges,
        // bad continuation bytes (a new lead among them) and the largest value.
        directed = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
                     8'hC2, 8'hA9,
                     8'hE4, 8'hB8, 8'h80,
                     8'hF0, 8'hA0, 8'h80, 8'h80,
                     8'hE4, 8'h41,
                     8'hC2, 8'hC3,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hEF, 8'hBF, 8'hBD};
        foreach (directed[i])
            send_byte(directed[i]);

        while (bytes_sent < BYTE_TARGET)
            send_random_char();

        @(negedge clk);
        s_tvalid = 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/utf8dw_pkg.sv
sv/utf8dw_width.sv
sv/utf8dw_decode.sv
sv/utf8_decode_with_display_width.sv
sv/utf8dw_checker.sv
tb/testbench.sv
